@@ hw/rtl/ir_tok_pkg.sv @@
// ----------------------------------------------------------------------------
// ir_tok_pkg
// Shared types, token codes and helper functions of the ir token scanner.
// ----------------------------------------------------------------------------
package ir_tok_pkg;

    // source offset counter width and kept word prefix
    localparam int POS_WIDTH    = 16;
    localparam int PREFIX_BYTES = 6;
    localparam int PFX_IDX_W    = $clog2(PREFIX_BYTES);
    localparam int MAX_TOKENS   = 3;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
    localparam logic [7:0]  LEN_MAX = 8'hFF;

    // scanner modes
    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_WORD = 3'd1;
    localparam logic [2:0] M_NUM  = 3'd2;
    localparam logic [2:0] M_EQ   = 3'd3;
    localparam logic [2:0] M_LT   = 3'd4;
    localparam logic [2:0] M_GT   = 3'd5;
    localparam logic [2:0] M_DONE = 3'd6;

    // token kinds
    localparam logic [3:0] K_FUNC   = 4'd0;
    localparam logic [3:0] K_ID     = 4'd1;
    localparam logic [3:0] K_BLOCK  = 4'd2;
    localparam logic [3:0] K_OP     = 4'd3;
    localparam logic [3:0] K_NUM    = 4'd4;
    localparam logic [3:0] K_PHI    = 4'd5;
    localparam logic [3:0] K_BR     = 4'd6;
    localparam logic [3:0] K_RETURN = 4'd7;
    localparam logic [3:0] K_LCURL  = 4'd8;
    localparam logic [3:0] K_RCURL  = 4'd9;
    localparam logic [3:0] K_LPAREN = 4'd10;
    localparam logic [3:0] K_RPAREN = 4'd11;
    localparam logic [3:0] K_COMMA  = 4'd12;
    localparam logic [3:0] K_END    = 4'd13;
    localparam logic [3:0] K_ERROR  = 4'd14;

    // operator codes
    localparam logic [3:0] OP_COLON = 4'd0;
    localparam logic [3:0] OP_SEMI  = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_SUB   = 4'd4;
    localparam logic [3:0] OP_MOD   = 4'd5;
    localparam logic [3:0] OP_ASSIGN = 4'd6;
    localparam logic [3:0] OP_EQ    = 4'd7;
    localparam logic [3:0] OP_LT    = 4'd8;
    localparam logic [3:0] OP_LE    = 4'd9;
    localparam logic [3:0] OP_GT    = 4'd10;
    localparam logic [3:0] OP_GE    = 4'd11;

    // one token, kind in the lowest bits
    typedef struct packed {
        logic [7:0]  token_len;
        logic [15:0] start_pos;
        logic        number_overflow;
        logic [30:0] number_value;
        logic [3:0]  op_code;
        logic [3:0]  kind;
    } tok_t;

    typedef logic [PREFIX_BYTES-1:0][7:0] prefix_t;

    // tokens caused by one source byte, in order
    typedef struct packed {
        logic [1:0]                 cnt;
        tok_t [MAX_TOKENS-1:0]      toks;
    } bundle_t;

    function automatic tok_t mk_tok(logic [3:0] kind, logic [3:0] op,
                                    logic [15:0] start, logic [7:0] len);
        tok_t t;
        t                 = '0;
        t.kind            = kind;
        t.op_code         = op;
        t.start_pos       = start;
        t.token_len       = len;
        return t;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_pending(logic [2:0] mode);
        return (mode == M_WORD) || (mode == M_NUM) || (mode == M_EQ) ||
               (mode == M_LT) || (mode == M_GT);
    endfunction

    // returns {saturated, value}; acc*10 + d built from shifts
    function automatic logic [31:0] add_digit(logic [30:0] acc, logic sat, logic [7:0] c);
        logic [34:0] sum;
        logic [3:0]  d;
        d   = 4'(c - "0");
        sum = {acc, 3'b000} + {3'b000, acc, 1'b0} + 35'(d);
        if (sat || (sum > 35'(NUM_MAX))) begin
            return {1'b1, NUM_MAX};
        end
        return {1'b0, sum[30:0]};
    endfunction

    function automatic logic [3:0] word_kind(prefix_t p, logic [7:0] len);
        if ((len == 8'd3) && (p[0] == "p") && (p[1] == "h") && (p[2] == "i")) begin
            return K_PHI;
        end
        if ((len == 8'd2) && (p[0] == "b") && (p[1] == "r")) begin
            return K_BR;
        end
        if ((len == 8'd6) && (p[0] == "r") && (p[1] == "e") && (p[2] == "t") &&
            (p[3] == "u") && (p[4] == "r") && (p[5] == "n")) begin
            return K_RETURN;
        end
        if ((len == 8'd3) && (p[0] == "i") && (p[1] == "n") && (p[2] == "t")) begin
            return K_FUNC;
        end
        if ((len >= 8'd3) && (p[0] == "b") && (p[1] == "b") && is_digit(p[2])) begin
            return K_BLOCK;
        end
        return K_ID;
    endfunction

    // token for a word, number or single-char compare still open in the scanner
    function automatic tok_t pend_tok(logic [2:0] mode, prefix_t p, logic [7:0] len,
                                      logic [30:0] acc, logic sat, logic [15:0] start);
        tok_t t;
        t = mk_tok(K_OP, OP_ASSIGN, start, 8'd1);
        case (mode)
            M_WORD: begin
                t = mk_tok(word_kind(p, len), OP_COLON, start, len);
            end
            M_NUM: begin
                t                 = mk_tok(K_NUM, OP_COLON, start, len);
                t.number_value    = acc;
                t.number_overflow = sat;
            end
            M_LT: begin
                t = mk_tok(K_OP, OP_LT, start, 8'd1);
            end
            M_GT: begin
                t = mk_tok(K_OP, OP_GT, start, 8'd1);
            end
            default: begin
                t = mk_tok(K_OP, OP_ASSIGN, start, 8'd1);
            end
        endcase
        return t;
    endfunction

endpackage

@@ hw/rtl/ir_token_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// ir_token_scanner_unit
// Streaming tokenizer for a small IR text: one source byte in, tokens out.
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata                          | tlast
//  ----------+-----+--------------------------------+-------------------------
//  s_axis    | in  | ch                             | end_of_source
//  m_axis    | out | kind, op_code, number_value,   | last_of_run
//            |     | number_overflow, start_pos,    |
//            |     | token_len                      |
//
//  flow: each byte moves from the input register through the scan logic
//  into the result register, so one byte per cycle is sustained while each
//  byte gives at most one token and m_axis_tready stays high
//  a byte that gives k tokens (k up to 3) holds the result register until
//  all k are taken, since the m_axis port moves one token per transaction
//  reset: synchronous on aresetn low; scanner returns to idle at offset 0
//  stalls: m_axis_tready low holds the result register; the input register
//  still takes one more byte before s_axis_tready drops
//
module ir_token_scanner_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input transactions
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // end_of_source
    // result transactions
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [3:0] kind, [7:4] op_code,
                                        // [38:8] number_value, [39] number_overflow,
                                        // [55:40] start_pos, [63:56] token_len
    output logic        m_axis_tlast    // last_of_run
);

    // input register
    logic                in_vld_reg;
    logic [7:0]          ch_reg;
    logic                eos_reg;

    logic                s_take;
    logic                free;
    logic                move;
    ir_tok_pkg::bundle_t bundle;

    // a byte moves on once the result register is empty or about to empty
    assign move          = in_vld_reg && free;
    assign s_axis_tready = !in_vld_reg || move;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_take) begin
            in_vld_reg <= 1'b1;
        end else if (move) begin
            in_vld_reg <= 1'b0;
        end
    end

    // byte and end flag need no reset, qualified by in_vld_reg
    always_ff @(posedge aclk) begin
        if (s_take) begin
            ch_reg  <= s_axis_tdata;
            eos_reg <= s_axis_tlast;
        end
    end

    // scanner state and token building
    ir_tok_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (move),
        .ch      (ch_reg),
        .eos     (eos_reg),
        .bundle  (bundle)
    );

    // result register and token serializer
    ir_tok_outbuf u_outbuf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (move),
        .bundle        (bundle),
        .free          (free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ hw/rtl/ir_tok_scan.sv @@
// ----------------------------------------------------------------------------
// ir_tok_scan
// Scanner state and per-byte token logic; yields up to three tokens per byte.
// ----------------------------------------------------------------------------
module ir_tok_scan (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,
    input  logic [7:0]               ch,
    input  logic                     eos,
    output ir_tok_pkg::bundle_t      bundle
);

    logic [2:0]                          mode_reg, mode_next;
    ir_tok_pkg::prefix_t                 prefix_reg, prefix_next;
    logic [7:0]                          len_reg, len_next;
    logic [30:0]                         acc_reg, acc_next;
    logic                                sat_reg, sat_next;
    logic [ir_tok_pkg::POS_WIDTH-1:0]    start_reg, start_next;
    logic [ir_tok_pkg::POS_WIDTH-1:0]    pos_reg, pos_next;

    ir_tok_pkg::tok_t [3:0]              cand;
    logic [3:0]                          cand_v;
    logic [ir_tok_pkg::POS_WIDTH-1:0]    pos_inc;
    logic [15:0]                         pos16;
    logic                                active;
    logic                                word_ch;
    logic                                two_op;
    logic [3:0]                          op2;
    logic [1:0]                          n;

    assign pos_inc = pos_reg + 1'b1;
    assign pos16   = 16'(pos_reg);
    assign active  = (mode_reg != ir_tok_pkg::M_DONE);
    assign word_ch = ir_tok_pkg::is_alpha(ch) || ir_tok_pkg::is_digit(ch) || (ch == "_");
    assign two_op  = ((mode_reg == ir_tok_pkg::M_EQ) || (mode_reg == ir_tok_pkg::M_LT) ||
                      (mode_reg == ir_tok_pkg::M_GT)) && (ch == "=");

    always_comb begin
        case (mode_reg)
            ir_tok_pkg::M_LT: op2 = ir_tok_pkg::OP_LE;
            ir_tok_pkg::M_GT: op2 = ir_tok_pkg::OP_GE;
            default:          op2 = ir_tok_pkg::OP_EQ;
        endcase
    end

    always_comb begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        acc_next    = acc_reg;
        sat_next    = sat_reg;
        start_next  = start_reg;
        cand        = '0;
        cand_v      = '0;

        if (active) begin
            if ((mode_reg == ir_tok_pkg::M_WORD) && word_ch) begin
                if (len_reg < 8'(ir_tok_pkg::PREFIX_BYTES)) begin
                    prefix_next[len_reg[ir_tok_pkg::PFX_IDX_W-1:0]] = ch;
                end
                if (len_reg != ir_tok_pkg::LEN_MAX) begin
                    len_next = len_reg + 8'd1;
                end
            end else if ((mode_reg == ir_tok_pkg::M_NUM) && ir_tok_pkg::is_digit(ch)) begin
                {sat_next, acc_next} = ir_tok_pkg::add_digit(acc_reg, sat_reg, ch);
                if (len_reg != ir_tok_pkg::LEN_MAX) begin
                    len_next = len_reg + 8'd1;
                end
            end else if (two_op) begin
                cand[0]   = ir_tok_pkg::mk_tok(ir_tok_pkg::K_OP, op2, 16'(start_reg), 8'd2);
                cand_v[0] = 1'b1;
                mode_next = ir_tok_pkg::M_IDLE;
            end else begin
                // close whatever the byte ends, then look at the byte itself
                if (ir_tok_pkg::is_pending(mode_reg)) begin
                    cand[0]   = ir_tok_pkg::pend_tok(mode_reg, prefix_reg, len_reg,
                                                     acc_reg, sat_reg, 16'(start_reg));
                    cand_v[0] = 1'b1;
                end
                mode_next = ir_tok_pkg::M_IDLE;
                if (ir_tok_pkg::is_space(ch)) begin
                    mode_next = ir_tok_pkg::M_IDLE;
                end else if (ir_tok_pkg::is_alpha(ch) || (ch == "_")) begin
                    prefix_next    = '0;
                    prefix_next[0] = ch;
                    len_next       = 8'd1;
                    start_next     = pos_reg;
                    mode_next      = ir_tok_pkg::M_WORD;
                end else if (ir_tok_pkg::is_digit(ch)) begin
                    {sat_next, acc_next} = ir_tok_pkg::add_digit(31'd0, 1'b0, ch);
                    len_next   = 8'd1;
                    start_next = pos_reg;
                    mode_next  = ir_tok_pkg::M_NUM;
                end else begin
                    cand_v[1] = 1'b1;
                    case (ch)
                        "{": cand[1] = ir_tok_pkg::mk_tok(ir_tok_pkg::K_LCURL,
                                                          ir_tok_pkg::OP_COLON, pos16, 8'd1);
                        "}": cand[1] = ir_tok_pkg::mk_tok(ir_tok_pkg::K_RCURL,
                                                          ir_tok_pkg::OP_COLON, pos16, 8'd1);
                        "(": cand[1] = ir_tok_pkg::mk_tok(ir_tok_pkg::K_LPAREN,
                                                          ir_tok_pkg::OP_COLON, pos16, 8'd1);
                        ")": cand[1] = ir_tok_pkg::mk_tok(ir_tok_pkg::K_RPAREN,
                                                          ir_tok_pkg::OP_COLON, pos16, 8'd1);
                        ",": cand[1] = ir_tok_pkg::mk_tok(ir_tok_pkg::K_COMMA,
                                                          ir_tok_pkg::OP_COLON, pos16, 8'd1);
                        ":": cand[1] = ir_tok_pkg::mk_tok(ir_tok_pkg::K_OP,
                                                          ir_tok_pkg::OP_COLON, pos16, 8'd1);
                        ";": cand[1] = ir_tok_pkg::mk_tok(ir_tok_pkg::K_OP,
                                                          ir_tok_pkg::OP_SEMI, pos16, 8'd1);
                        "*": cand[1] = ir_tok_pkg::mk_tok(ir_tok_pkg::K_OP,
                                                          ir_tok_pkg::OP_MUL, pos16, 8'd1);
                        "+": cand[1] = ir_tok_pkg::mk_tok(ir_tok_pkg::K_OP,
                                                          ir_tok_pkg::OP_ADD, pos16, 8'd1);
                        "-": cand[1] = ir_tok_pkg::mk_tok(ir_tok_pkg::K_OP,
                                                          ir_tok_pkg::OP_SUB, pos16, 8'd1);
                        "%": cand[1] = ir_tok_pkg::mk_tok(ir_tok_pkg::K_OP,
                                                          ir_tok_pkg::OP_MOD, pos16, 8'd1);
                        "=": begin
                            cand_v[1]  = 1'b0;
                            start_next = pos_reg;
                            mode_next  = ir_tok_pkg::M_EQ;
                        end
                        "<": begin
                            cand_v[1]  = 1'b0;
                            start_next = pos_reg;
                            mode_next  = ir_tok_pkg::M_LT;
                        end
                        ">": begin
                            cand_v[1]  = 1'b0;
                            start_next = pos_reg;
                            mode_next  = ir_tok_pkg::M_GT;
                        end
                        "$": begin
                            cand[1]   = ir_tok_pkg::mk_tok(ir_tok_pkg::K_END,
                                                           ir_tok_pkg::OP_COLON, pos16, 8'd1);
                            mode_next = ir_tok_pkg::M_DONE;
                        end
                        default: begin
                            cand[1]   = ir_tok_pkg::mk_tok(ir_tok_pkg::K_ERROR,
                                                           ir_tok_pkg::OP_COLON, pos16, 8'd1);
                            mode_next = ir_tok_pkg::M_DONE;
                        end
                    endcase
                end
            end

            // end of source closes the open token and adds an implicit end
            if (eos && (mode_next != ir_tok_pkg::M_DONE)) begin
                if (ir_tok_pkg::is_pending(mode_next)) begin
                    cand[2]   = ir_tok_pkg::pend_tok(mode_next, prefix_next, len_next,
                                                     acc_next, sat_next, 16'(start_next));
                    cand_v[2] = 1'b1;
                end
                cand[3]   = ir_tok_pkg::mk_tok(ir_tok_pkg::K_END, ir_tok_pkg::OP_COLON,
                                               16'(pos_inc), 8'd0);
                cand_v[3] = 1'b1;
            end
        end

        if (eos) begin
            mode_next = ir_tok_pkg::M_IDLE;
            pos_next  = '0;
        end else begin
            pos_next  = pos_inc;
        end
    end

    // pack the valid candidates into the low slots, in order
    always_comb begin
        bundle = '0;
        n      = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && (n != 2'd3)) begin
                bundle.toks[n] = cand[i];
                n              = n + 2'd1;
            end
        end
        bundle.cnt = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ir_tok_pkg::M_IDLE;
            pos_reg  <= '0;
        end else if (step) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            acc_reg    <= acc_next;
            sat_reg    <= sat_next;
            start_reg  <= start_next;
        end
    end

endmodule

@@ hw/rtl/ir_tok_outbuf.sv @@
// ----------------------------------------------------------------------------
// ir_tok_outbuf
// Result register: holds the tokens of one byte and hands them out one by one.
// ----------------------------------------------------------------------------
module ir_tok_outbuf (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  ir_tok_pkg::bundle_t      bundle,
    output logic                     free,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [63:0]              m_axis_tdata,
    output logic                     m_axis_tlast
);

    ir_tok_pkg::tok_t [ir_tok_pkg::MAX_TOKENS-1:0] tok_reg, tok_next;
    logic [1:0]                                    cnt_reg, cnt_next;
    logic                                          pop;

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = tok_reg[0];
    assign m_axis_tlast  = (cnt_reg == 2'd1);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign free          = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);

    always_comb begin
        tok_next = tok_reg;
        cnt_next = cnt_reg;
        if (load) begin
            tok_next = bundle.toks;
            cnt_next = bundle.cnt;
        end else if (pop) begin
            tok_next[0] = tok_reg[1];
            tok_next[1] = tok_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
    end

endmodule

@@ hw/rtl/ir_tok_checker.sv @@
// ----------------------------------------------------------------------------
// ir_tok_checker
// Port-level checks of the token scanner, bound to the top level.
// ----------------------------------------------------------------------------
module ir_tok_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled token holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled token changed");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("token valid after reset");

    // only operators carry an operator code
    a_opcode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[3:0] != ir_tok_pkg::K_OP) |->
            (m_axis_tdata[7:4] == ir_tok_pkg::OP_COLON))
        else $error("op code on non-operator token");

    // saturated numbers show the maximum value
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[39] |->
            (m_axis_tdata[3:0] == ir_tok_pkg::K_NUM) &&
            (m_axis_tdata[38:8] == ir_tok_pkg::NUM_MAX))
        else $error("overflow flag without saturated number");

    // only the implicit end token has zero length
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[63:56] == 8'd0) |->
            (m_axis_tdata[3:0] == ir_tok_pkg::K_END) && m_axis_tlast)
        else $error("empty token that is not a final end token");

endmodule

bind ir_token_scanner_unit ir_tok_checker u_ir_tok_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ir_token_scanner_unit: source bytes are streamed in
// and every token is compared against a behavioral scanner kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import ir_tok_pkg::*;

    // op_code carried by tokens that are not operators
    localparam logic [3:0] OP_NONE        = 4'd0;
    localparam int         RAND_PER_PHASE = 10;

    // one expected token plus the last-of-run marker
    typedef struct packed {
        tok_t tok;
        logic last;
    } tok_exp_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] ch
    logic        s_axis_tlast;   // end_of_source
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [3:0] kind, [7:4] op_code, [38:8] number_value,
                                 // [39] number_overflow, [55:40] start_pos,
                                 // [63:56] token_len
    logic        m_axis_tlast;   // last_of_run

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          errors;

    // tokens still owed by the scanner, oldest first
    tok_exp_t    expected_tokens[$];
    tok_t        step_tokens[$];
    logic [7:0]  src_bytes[$];

    // bench copy of the scanner state
    logic [2:0]           sc_mode;
    logic [7:0]           sc_pfx [PREFIX_BYTES];
    logic [7:0]           sc_len;
    logic [30:0]          sc_acc;
    logic                 sc_sat;
    logic [15:0]          sc_start;
    logic [POS_WIDTH-1:0] sc_pos;

    string      keywords[4]    = '{"phi", "br", "return", "int"};
    string      near_words[10] = '{"ph", "phix", "retur", "returns", "in", "intx",
                                   "b", "brr", "bb", "bbx"};
    string      big_numbers[3] = '{"2147483647", "2147483648", "99999999999"};
    string      op_texts[12]   = '{":", ";", "*", "+", "-", "%", "=", "==", "<", "<=",
                                   ">", ">="};
    string      punct_texts[5] = '{"{", "}", "(", ")", ","};
    logic [7:0] blank_chars[6] = '{8'd32, 8'd9, 8'd10, 8'd13, 8'd11, 8'd12};

    ir_token_scanner_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // scanner prediction
    // ------------------------------------------------------------------------
    function automatic logic char_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic char_letter(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic char_blank(logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic void add_token(logic [3:0] kind, logic [3:0] op, logic [30:0] val,
                                      logic ovf, logic [15:0] start, logic [7:0] len);
        tok_t t;
        t.kind            = kind;
        t.op_code         = op;
        t.number_value    = val;
        t.number_overflow = ovf;
        t.start_pos       = start;
        t.token_len       = len;
        step_tokens.push_back(t);
    endfunction

    // keywords need the exact length, block names only the kept prefix
    function automatic logic [3:0] word_token_kind();
        if (sc_len == 8'd3 && sc_pfx[0] == "p" && sc_pfx[1] == "h" && sc_pfx[2] == "i")
            return K_PHI;
        if (sc_len == 8'd2 && sc_pfx[0] == "b" && sc_pfx[1] == "r")
            return K_BR;
        if (sc_len == 8'd6 && sc_pfx[0] == "r" && sc_pfx[1] == "e" && sc_pfx[2] == "t" &&
            sc_pfx[3] == "u" && sc_pfx[4] == "r" && sc_pfx[5] == "n")
            return K_RETURN;
        if (sc_len == 8'd3 && sc_pfx[0] == "i" && sc_pfx[1] == "n" && sc_pfx[2] == "t")
            return K_FUNC;
        if (sc_len >= 8'd3 && sc_pfx[0] == "b" && sc_pfx[1] == "b" && char_digit(sc_pfx[2]))
            return K_BLOCK;
        return K_ID;
    endfunction

    // emit whatever word, number or single compare is still open
    function automatic void flush_open_token();
        case (sc_mode)
            M_WORD: add_token(word_token_kind(), OP_NONE, '0, 1'b0, sc_start, sc_len);
            M_NUM:  add_token(K_NUM, OP_NONE, sc_acc, sc_sat, sc_start, sc_len);
            M_EQ:   add_token(K_OP, OP_ASSIGN, '0, 1'b0, sc_start, 8'd1);
            M_LT:   add_token(K_OP, OP_LT, '0, 1'b0, sc_start, 8'd1);
            M_GT:   add_token(K_OP, OP_GT, '0, 1'b0, sc_start, 8'd1);
            default: ;
        endcase
        if (sc_mode != M_DONE)
            sc_mode = M_IDLE;
    endfunction

    // value sticks at the maximum once it would pass it
    function automatic void accumulate_digit(logic [7:0] c);
        logic [35:0] sum;
        sum = 36'(sc_acc) * 36'd10 + 36'(c - "0");
        if (sc_sat || sum > 36'(NUM_MAX)) begin
            sc_acc = NUM_MAX;
            sc_sat = 1'b1;
        end else begin
            sc_acc = sum[30:0];
        end
    endfunction

    function automatic void open_token(logic [7:0] c);
        logic [15:0] p;
        p = 16'(sc_pos);
        if (char_blank(c))
            return;
        if (char_letter(c) || c == "_") begin
            for (int i = 0; i < PREFIX_BYTES; i++)
                sc_pfx[i] = 8'd0;
            sc_pfx[0] = c;
            sc_len    = 8'd1;
            sc_start  = p;
            sc_mode   = M_WORD;
            return;
        end
        if (char_digit(c)) begin
            sc_acc = '0;
            sc_sat = 1'b0;
            accumulate_digit(c);
            sc_len   = 8'd1;
            sc_start = p;
            sc_mode  = M_NUM;
            return;
        end
        case (c)
            "{": add_token(K_LCURL, OP_NONE, '0, 1'b0, p, 8'd1);
            "}": add_token(K_RCURL, OP_NONE, '0, 1'b0, p, 8'd1);
            "(": add_token(K_LPAREN, OP_NONE, '0, 1'b0, p, 8'd1);
            ")": add_token(K_RPAREN, OP_NONE, '0, 1'b0, p, 8'd1);
            ",": add_token(K_COMMA, OP_NONE, '0, 1'b0, p, 8'd1);
            ":": add_token(K_OP, OP_COLON, '0, 1'b0, p, 8'd1);
            ";": add_token(K_OP, OP_SEMI, '0, 1'b0, p, 8'd1);
            "*": add_token(K_OP, OP_MUL, '0, 1'b0, p, 8'd1);
            "+": add_token(K_OP, OP_ADD, '0, 1'b0, p, 8'd1);
            "-": add_token(K_OP, OP_SUB, '0, 1'b0, p, 8'd1);
            "%": add_token(K_OP, OP_MOD, '0, 1'b0, p, 8'd1);
            "=": begin
                sc_start = p;
                sc_mode  = M_EQ;
            end
            "<": begin
                sc_start = p;
                sc_mode  = M_LT;
            end
            ">": begin
                sc_start = p;
                sc_mode  = M_GT;
            end
            "$": begin
                add_token(K_END, OP_NONE, '0, 1'b0, p, 8'd1);
                sc_mode = M_DONE;
            end
            default: begin
                add_token(K_ERROR, OP_NONE, '0, 1'b0, p, 8'd1);
                sc_mode = M_DONE;
            end
        endcase
    endfunction

    // tokens caused by one accepted byte, queued in order
    function automatic void predict_tokens(logic [7:0] c, logic eos);
        logic     taken;
        tok_exp_t e;
        taken = 1'b0;
        step_tokens.delete();
        if (sc_mode != M_DONE) begin
            if (sc_mode == M_WORD && (char_letter(c) || char_digit(c) || c == "_")) begin
                if (sc_len < PREFIX_BYTES)
                    sc_pfx[sc_len] = c;
                if (sc_len != LEN_MAX)
                    sc_len = sc_len + 8'd1;
                taken = 1'b1;
            end else if (sc_mode == M_NUM && char_digit(c)) begin
                accumulate_digit(c);
                if (sc_len != LEN_MAX)
                    sc_len = sc_len + 8'd1;
                taken = 1'b1;
            end else if ((sc_mode == M_EQ || sc_mode == M_LT || sc_mode == M_GT) &&
                         c == "=") begin
                add_token(K_OP, (sc_mode == M_EQ) ? OP_EQ : (sc_mode == M_LT) ? OP_LE : OP_GE,
                          '0, 1'b0, sc_start, 8'd2);
                sc_mode = M_IDLE;
                taken   = 1'b1;
            end else begin
                flush_open_token();
            end
            if (!taken)
                open_token(c);
            // implicit end sits one byte past the last one, zero length
            if (eos && sc_mode != M_DONE) begin
                flush_open_token();
                add_token(K_END, OP_NONE, '0, 1'b0, 16'(sc_pos + 1'b1), 8'd0);
            end
        end
        if (eos) begin
            sc_mode = M_IDLE;
            sc_pos  = '0;
        end else begin
            sc_pos = sc_pos + 1'b1;
        end
        for (int i = 0; i < step_tokens.size(); i++) begin
            e.tok  = step_tokens[i];
            e.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(e);
        end
    endfunction

    // ------------------------------------------------------------------------
    // token checking
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : token_check
        tok_t     got;
        tok_exp_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected token, expected none actual %h", $time,
                         m_axis_tdata);
            end else begin
                want = expected_tokens.pop_front();
                check_field("kind", want.tok.kind, got.kind);
                check_field("op_code", want.tok.op_code, got.op_code);
                check_field("number_value", want.tok.number_value, got.number_value);
                check_field("number_overflow", want.tok.number_overflow, got.number_overflow);
                check_field("start_pos", want.tok.start_pos, got.start_pos);
                check_field("token_len", want.tok.token_len, got.token_len);
                check_field("last_of_run", want.last, m_axis_tlast);
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // byte sending
    // ------------------------------------------------------------------------
    // enters and leaves at a falling edge; valid stays high into the next byte
    task automatic send_byte(logic [7:0] c, logic eos);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eos;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        predict_tokens(c, eos);
        @(negedge aclk);
    endtask

    task automatic send_text(string s, logic eos_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eos_last && (i == s.len() - 1));
    endtask

    // hold off the sender until the scanner has caught up
    task automatic wait_tokens_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 3))
            0: return 8'("a" + $urandom_range(0, 25));
            1: return 8'("A" + $urandom_range(0, 25));
            2: return 8'("0" + $urandom_range(0, 9));
            default: return "_";
        endcase
    endfunction

    task automatic append_text(string s);
        for (int i = 0; i < s.len(); i++)
            src_bytes.push_back(s[i]);
    endtask

    task automatic append_random_token();
        case ($urandom_range(0, 5))
            0: append_text(keywords[$urandom_range(0, 3)]);
            1: begin
                append_text("bb");
                src_bytes.push_back(8'("0" + $urandom_range(0, 9)));
                repeat ($urandom_range(0, 3)) src_bytes.push_back(rand_word_char());
            end
            2: begin
                if ($urandom_range(0, 1)) begin
                    append_text(near_words[$urandom_range(0, 9)]);
                end else begin
                    src_bytes.push_back($urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                                             : 8'("_"));
                    repeat ($urandom_range(0, 9)) src_bytes.push_back(rand_word_char());
                end
            end
            3: begin
                if ($urandom_range(0, 7) == 0)
                    append_text(big_numbers[$urandom_range(0, 2)]);
                else
                    repeat ($urandom_range(1, 12))
                        src_bytes.push_back(8'("0" + $urandom_range(0, 9)));
            end
            4: append_text(op_texts[$urandom_range(0, 11)]);
            default: append_text(punct_texts[$urandom_range(0, 4)]);
        endcase
    endtask

    // mostly well-formed sources with random content, some noise and early ends;
    // the last source is cut short so that exactly n_bytes are sent
    task automatic send_random_sources(int n_bytes);
        int sent;
        int r;
        int n_send;
        sent = 0;
        while (sent < n_bytes) begin
            src_bytes.delete();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) src_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    append_random_token();
                    r = $urandom_range(0, 99);
                    if (r < 8) begin
                        src_bytes.push_back(8'($urandom_range(0, 255)));
                    end else if (r < 12) begin
                        src_bytes.push_back("$");
                        repeat ($urandom_range(0, 3))
                            src_bytes.push_back(8'($urandom_range(0, 255)));
                    end else if (r < 65) begin
                        repeat ($urandom_range(1, 2))
                            src_bytes.push_back(blank_chars[$urandom_range(0, 5)]);
                    end
                end
            end
            n_send = src_bytes.size();
            if (n_send > n_bytes - sent)
                n_send = n_bytes - sent;
            for (int i = 0; i < n_send; i++)
                send_byte(src_bytes[i], i == n_send - 1);
            sent += n_send;
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_keywords();
        send_text("phi br return int bb7 bbq _Z9", 1'b1);
    endtask

    // adjacent compares: a pending one is closed by the next byte
    task automatic test_operators();
        send_text("{}(),:;*+-%= ==<<=>>=", 1'b1);
    endtask

    // includes the saturation point and digits running into a word
    task automatic test_numbers();
        send_text("0 2147483647 2147483648 12ab", 1'b1);
    endtask

    task automatic test_end_markers();
        send_text("a=", 1'b1);       // word, pending assign and end on one byte
        send_text("ab$zz", 1'b1);    // bytes after the marker are dropped
        send_byte(8'h00, 1'b0);      // control byte is an error
        send_text("yy", 1'b1);
        send_byte(8'hFF, 1'b1);      // error on the final byte, no extra end
        send_text(" \t", 1'b1);      // blank source gives only the end
        send_text("q", 1'b1);
    endtask

    // a keyword as kept prefix is still an id, and the length sticks at 255
    task automatic test_long_tokens();
        send_text("return", 1'b0);
        repeat (250) send_byte("x", 1'b0);
        send_byte(";", 1'b1);
    endtask

    initial begin
        errors        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        sc_mode       = M_IDLE;
        sc_len        = 8'd0;
        sc_acc        = '0;
        sc_sat        = 1'b0;
        sc_start      = '0;
        sc_pos        = '0;
        for (int i = 0; i < PREFIX_BYTES; i++)
            sc_pfx[i] = 8'd0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // sender mostly busy, receiver stalls often
        send_idle_pct = 22;
        recv_idle_pct = 65;
        test_keywords();
        test_operators();
        test_numbers();
        test_end_markers();
        wait_tokens_drained();
        send_random_sources(RAND_PER_PHASE);
        wait_tokens_drained();

        // sender gaps dominate
        send_idle_pct = 65;
        recv_idle_pct = 22;
        test_long_tokens();
        send_random_sources(RAND_PER_PHASE);
        wait_tokens_drained();

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_sources(RAND_PER_PHASE);
        wait_tokens_drained();

        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ ir_token_scanner_unit.f @@
hw/rtl/ir_tok_pkg.sv
hw/rtl/ir_tok_scan.sv
hw/rtl/ir_tok_outbuf.sv
hw/rtl/ir_token_scanner_unit.sv
hw/rtl/ir_tok_checker.sv
tb/tb_top.sv
